// ===== hdl/aab_pkg.sv =====
`default_nettype none
package aab_pkg;

  localparam int CHANNELS_DEF  = 64;
  localparam int CODE_BITS_DEF = 16;

  localparam int CHAN_W   = 6;
  localparam int IN_CODE_W = 16;
  localparam int ACT_W    = 7;
  localparam int COUNT_W  = 16;

  localparam logic [ACT_W-1:0] ACTIVE_RESET = 7'd64;

  localparam logic [1:0] ST_NORMAL = 2'd0;
  localparam logic [1:0] ST_ALARM  = 2'd1;
  localparam logic [1:0] ST_ACCEPT = 2'd2;
  localparam logic [1:0] ST_RETURN = 2'd3;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_REFUSED = 2'd1;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd2;
  localparam logic [1:0] STATUS_ABSENT  = 2'd3;

  localparam logic [1:0] CMD_SUPPRESS   = 2'd0;
  localparam logic [1:0] CMD_UNSUPPRESS = 2'd1;
  localparam logic [1:0] CMD_ACK        = 2'd2;

  localparam logic MODE_SCAN = 1'b0;

  localparam int FL_ERR   = 0;
  localparam int FL_UNACK = 1;
  localparam int FL_NEW   = 2;

  typedef struct packed {
    logic [1:0]           command;
    logic [IN_CODE_W-1:0] fault_code;
    logic                 fault;
    logic [CHAN_W-1:0]    channel;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] change_count;
    logic [2:0]         flags;
    logic [1:0]         channel_state;
    logic [1:0]         status;
  } out_word_t;

  localparam int IN_ITEM_W  = $bits(in_item_t);
  localparam int OUT_WORD_W = $bits(out_word_t);
  localparam int IN_DATA_W  = ((IN_ITEM_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((OUT_WORD_W + 7) / 8) * 8;

  typedef struct packed {
    logic clr_step;
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
  } ctrl_stat_t;

endpackage
`default_nettype wire

// ===== hdl/aab_ram.sv =====
`default_nettype none
module aab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/aab_ctrl.sv =====
`default_nettype none
module aab_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output aab_pkg::ctrl_cmd_t      cmd,
  input  wire aab_pkg::ctrl_stat_t stat
);
  import aab_pkg::*;

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd.clr_step = (state_r == S_CLR);
    cmd.capture  = (state_r == S_IDLE) && in_tvalid;
    cmd.commit   = (state_r == S_EXEC) && (!out_valid_r || out_tready);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cmd.capture) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_comb begin
    if (cmd.commit) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

// ===== hdl/aab_dp.sv =====
`default_nettype none
module aab_dp #(
  parameter int CHANNELS  = aab_pkg::CHANNELS_DEF,
  parameter int CODE_BITS = aab_pkg::CODE_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire aab_pkg::ctrl_cmd_t        cmd,
  output aab_pkg::ctrl_stat_t            stat,
  input  wire aab_pkg::in_item_t         in_item,
  input  wire logic                      in_mode,
  input  wire logic                      in_last,
  input  wire logic                      cfg_wr,
  input  wire logic [aab_pkg::ACT_W-1:0] cfg_data,
  output aab_pkg::out_word_t             out_word,
  output logic                           out_last
);
  import aab_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ENT_W = CODE_BITS + 3;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

  logic [IDX_W-1:0]     clr_cnt_r;
  logic                 mode_r;
  logic [CHAN_W-1:0]    chan_r;
  logic                 fault_r;
  logic [CODE_BITS-1:0] code_r;
  logic                 last_r;
  logic [1:0]           cmd_r;
  logic [ACT_W-1:0]     active_r;
  logic [2:0]           flags_r, flags_nxt;
  logic                 changed_r, changed_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  out_word_t            out_word_r;
  logic                 out_last_r;

  logic [ENT_W-1:0]     rd_q;
  logic [1:0]           rd_st;
  logic [CODE_BITS-1:0] rd_code;
  logic                 rd_supp;
  logic                 present;
  logic [IDX_W-1:0]     chan_idx;

  logic [1:0]           st_new;
  logic [CODE_BITS-1:0] code_new;
  logic                 supp_new;
  logic [1:0]           status;
  logic [2:0]           add;
  logic                 chg;
  logic                 cnt_inc;
  logic [2:0]           flags_out;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ENT_W-1:0]     ram_wdata;

  assign rd_st    = rd_q[1:0];
  assign rd_code  = rd_q[CODE_BITS+1:2];
  assign rd_supp  = rd_q[CODE_BITS+2];
  assign chan_idx = IDX_W'(chan_r);
  assign present  = ({1'b0, chan_r} < active_r) && (32'(chan_r) < 32'(CHANNELS));

  always_comb begin
    st_new      = rd_st;
    code_new    = rd_code;
    supp_new    = rd_supp;
    status      = STATUS_OK;
    add         = 3'b000;
    chg         = 1'b0;
    cnt_inc     = 1'b0;
    flags_out   = flags_r;
    flags_nxt   = flags_r;
    changed_nxt = changed_r;
    if (mode_r == MODE_SCAN) begin
      if (present) begin
        if (fault_r) begin
          if (rd_code != code_r) begin
            code_new = code_r;
            chg      = 1'b1;
          end
          if (rd_st == ST_ALARM) begin
            add[FL_UNACK] = 1'b1;
          end else if (rd_st == ST_NORMAL || rd_st == ST_RETURN) begin
            st_new        = ST_ALARM;
            chg           = 1'b1;
            add[FL_NEW]   = 1'b1;
            add[FL_UNACK] = 1'b1;
          end
          add[FL_ERR] = 1'b1;
          if (rd_supp) add = 3'b000;
        end else begin
          if (rd_st == ST_ACCEPT) begin
            st_new = ST_NORMAL;
            chg    = 1'b1;
          end else if (rd_st == ST_ALARM) begin
            st_new = ST_RETURN;
            chg    = 1'b1;
          end
        end
      end else begin
        status = STATUS_ABSENT;
      end
      flags_out   = flags_r | add;
      flags_nxt   = flags_out;
      changed_nxt = changed_r | chg;
      if (last_r) begin
        cnt_inc     = changed_nxt;
        flags_nxt   = 3'b000;
        changed_nxt = 1'b0;
      end
    end else begin
      if (present) begin
        case (cmd_r)
          CMD_SUPPRESS:   supp_new = 1'b1;
          CMD_UNSUPPRESS: supp_new = 1'b0;
          CMD_ACK: begin
            if (rd_st == ST_ALARM) st_new = ST_ACCEPT;
            else if (rd_st == ST_RETURN) st_new = ST_NORMAL;
            else status = STATUS_REFUSED;
          end
          default: status = STATUS_UNKNOWN;
        endcase
        cnt_inc = (status == STATUS_OK);
      end else begin
        status = STATUS_ABSENT;
      end
    end
  end

  assign count_nxt = count_r + COUNT_W'(cnt_inc);

  assign ram_we    = cmd.clr_step || (cmd.commit && present);
  assign ram_waddr = cmd.clr_step ? clr_cnt_r : chan_idx;
  assign ram_wdata = cmd.clr_step ? '0 : {supp_new, code_new, st_new};

  aab_ram #(
    .WIDTH(ENT_W),
    .DEPTH(CHANNELS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.capture),
    .raddr(IDX_W'(in_item.channel)),
    .rdata(rd_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      active_r  <= ACTIVE_RESET;
      flags_r   <= 3'b000;
      changed_r <= 1'b0;
      count_r   <= '0;
    end else begin
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      if (cfg_wr) active_r <= cfg_data;
      if (cmd.commit) begin
        flags_r   <= flags_nxt;
        changed_r <= changed_nxt;
        count_r   <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= in_mode;
      chan_r  <= in_item.channel;
      fault_r <= in_item.fault;
      code_r  <= CODE_BITS'(in_item.fault_code);
      last_r  <= in_last;
      cmd_r   <= in_item.command;
    end
    if (cmd.commit) begin
      out_word_r.status        <= status;
      out_word_r.channel_state <= present ? st_new : ST_NORMAL;
      out_word_r.flags         <= flags_out;
      out_word_r.change_count  <= count_nxt;
      out_last_r               <= (mode_r == MODE_SCAN) && last_r;
    end
  end

  assign stat.clr_last = (clr_cnt_r == LAST_IDX);
  assign out_word      = out_word_r;
  assign out_last      = out_last_r;

endmodule
`default_nettype wire

// ===== hdl/alarm_annunciator_bank.sv =====
`default_nettype none
// Bank of per-channel alarm acknowledge state machines.
// The in_ channel carries one item per transfer: a scan sample of one channel
// (in_tuser low) or an operator command (in_tuser high). in_tlast marks the final
// sample of a scan pass. Every accepted item produces exactly one result transfer
// on the out_ channel, in order; out_tlast marks the result that closes a pass.
// The cfg_ channel writes the number of active channels; it is always ready and
// should only be written while no item is in flight.
// An item is handled in order: the accepting edge issues the registered read of the
// channel table, and the update state then writes the entry and loads the output
// register, so the block accepts no new item until the last one is committed, and
// out_tvalid rises when that output register is loaded.
// A held output result does not block acceptance of the next item; that item
// waits in the update cycle until the output register is taken.
// After reset the channel table is cleared one entry per cycle, so in_tready
// stays low until every entry is cleared; configuration writes are taken meanwhile.
module alarm_annunciator_bank #(
  parameter int CHANNELS  = aab_pkg::CHANNELS_DEF,
  parameter int CODE_BITS = aab_pkg::CODE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // channel[5:0], fault[6], fault_code[22:7], command[24:23], zero fill above.
  input  wire logic [aab_pkg::IN_DATA_W-1:0]  in_tdata,
  // mode: low for a scan sample, high for an operator command.
  input  wire logic                           in_tuser,
  input  wire logic                           in_tlast,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // status[1:0], channel_state[3:2], any_error[4], any_unacked[5], new_error[6],
  // change_count[22:7], zero fill above.
  output logic [aab_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tlast,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [aab_pkg::ACT_W-1:0]      cfg_data
);
  import aab_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;
  in_item_t   in_item;
  out_word_t  out_word;

  assign in_item   = in_tdata[IN_ITEM_W-1:0];
  assign cfg_ready = 1'b1;
  assign out_tdata = OUT_DATA_W'(out_word);

  aab_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  aab_dp #(
    .CHANNELS (CHANNELS),
    .CODE_BITS(CODE_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .stat    (stat),
    .in_item (in_item),
    .in_mode (in_tuser),
    .in_last (in_tlast),
    .cfg_wr  (cfg_valid && cfg_ready),
    .cfg_data(cfg_data),
    .out_word(out_word),
    .out_last(out_tlast)
  );

endmodule
`default_nettype wire

// ===== hdl/aab_checker.sv =====
`default_nettype none
module aab_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_tready,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [aab_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                          out_tlast
);
  import aab_pkg::*;

  logic [1:0] status;
  logic [1:0] chan_state;

  assign status     = out_tdata[1:0];
  assign chan_state = out_tdata[3:2];

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("result or input readiness present right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  a_scan_close_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> status == STATUS_OK || status == STATUS_ABSENT)
    else $error("pass closed by a result with a command status");

  a_absent_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status == STATUS_ABSENT |-> chan_state == ST_NORMAL)
    else $error("absent channel reported a state");

  a_refused_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status == STATUS_REFUSED |->
      chan_state == ST_NORMAL || chan_state == ST_ACCEPT)
    else $error("refused acknowledge in an acknowledgeable state");

endmodule

bind alarm_annunciator_bank aab_checker u_aab_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast)
);
`default_nettype wire

// ===== test/alarm_annunciator_bank_test.sv =====
`timescale 1ns / 1ps

module alarm_annunciator_bank_test;
  import aab_pkg::*;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam logic MODE_COMMAND = 1'b1;
  localparam int NUM_CHANNELS = CHANNELS_DEF;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD = 400;
  localparam int PHASE_ITEMS = 240;
  localparam int TIMEOUT_NS = 10_000_000;

  typedef struct {
    logic [1:0] status;
    logic [1:0] channel_state;
    logic any_error;
    logic any_unacked;
    logic new_error;
    logic [COUNT_W-1:0] change_count;
    logic scan_done;
  } alarm_result_t;

  class annunciator_tracker;
    logic [1:0] chan_state [NUM_CHANNELS];
    logic [IN_CODE_W-1:0] chan_code [NUM_CHANNELS];
    logic chan_muted [NUM_CHANNELS];
    logic [2:0] pass_flags;
    logic pass_changed;
    logic [COUNT_W-1:0] change_total;
    logic [ACT_W-1:0] active_count;
    alarm_result_t expected_results[$];
    int mismatches;

    function new();
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        chan_state[i] = ST_NORMAL;
        chan_code[i] = '0;
        chan_muted[i] = 1'b0;
      end
      pass_flags = '0;
      pass_changed = 1'b0;
      change_total = '0;
      active_count = ACTIVE_RESET;
      mismatches = 0;
    endfunction

    function void note_item(input logic mode, input logic [CHAN_W-1:0] ch, input logic fault,
                            input logic [IN_CODE_W-1:0] code, input logic last,
                            input logic [1:0] cmd);
      alarm_result_t r;
      logic [1:0] st;
      logic [2:0] add;
      logic chg;
      logic present;
      r.status = STATUS_OK;
      r.channel_state = ST_NORMAL;
      r.scan_done = 1'b0;
      present = ch < active_count;
      st = present ? chan_state[ch] : ST_NORMAL;
      if (mode == MODE_SCAN) begin
        if (!present) begin
          r.status = STATUS_ABSENT;
        end else begin
          add = 3'b000;
          chg = 1'b0;
          if (fault) begin
            if (chan_code[ch] != code) begin
              chan_code[ch] = code;
              chg = 1'b1;
            end
            if (st == ST_ALARM) begin
              add[FL_UNACK] = 1'b1;
            end else if (st == ST_NORMAL || st == ST_RETURN) begin
              st = ST_ALARM;
              chg = 1'b1;
              add[FL_NEW] = 1'b1;
              add[FL_UNACK] = 1'b1;
            end
            add[FL_ERR] = 1'b1;
            if (chan_muted[ch]) add = 3'b000;
          end else if (st == ST_ACCEPT) begin
            st = ST_NORMAL;
            chg = 1'b1;
          end else if (st == ST_ALARM) begin
            st = ST_RETURN;
            chg = 1'b1;
          end
          chan_state[ch] = st;
          pass_flags = pass_flags | add;
          pass_changed = pass_changed | chg;
          r.channel_state = st;
        end
        r.any_error = pass_flags[FL_ERR];
        r.any_unacked = pass_flags[FL_UNACK];
        r.new_error = pass_flags[FL_NEW];
        if (last) begin
          if (pass_changed) change_total = change_total + 1'b1;
          r.scan_done = 1'b1;
          pass_flags = '0;
          pass_changed = 1'b0;
        end
      end else begin
        if (!present) begin
          r.status = STATUS_ABSENT;
        end else begin
          case (cmd)
            CMD_SUPPRESS: chan_muted[ch] = 1'b1;
            CMD_UNSUPPRESS: chan_muted[ch] = 1'b0;
            CMD_ACK: begin
              if (st == ST_ALARM) st = ST_ACCEPT;
              else if (st == ST_RETURN) st = ST_NORMAL;
              else r.status = STATUS_REFUSED;
            end
            default: r.status = STATUS_UNKNOWN;
          endcase
          chan_state[ch] = st;
          if (r.status == STATUS_OK) change_total = change_total + 1'b1;
          r.channel_state = st;
        end
        r.any_error = pass_flags[FL_ERR];
        r.any_unacked = pass_flags[FL_UNACK];
        r.new_error = pass_flags[FL_NEW];
      end
      r.change_count = change_total;
      expected_results = {expected_results, r};
    endfunction

    function void compare_field(input string name, input logic [COUNT_W-1:0] want,
                                input logic [COUNT_W-1:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(input logic [OUT_DATA_W-1:0] data, input logic last);
      alarm_result_t e;
      if (expected_results.size() == 0) begin
        $error("result transfer with no item outstanding: data %h", data);
        mismatches++;
        return;
      end
      e = expected_results.pop_front();
      compare_field("status", e.status, data[1:0]);
      compare_field("channel_state", e.channel_state, data[3:2]);
      compare_field("any_error", e.any_error, data[4]);
      compare_field("any_unacked", e.any_unacked, data[5]);
      compare_field("new_error", e.new_error, data[6]);
      compare_field("change_count", e.change_count, data[22:7]);
      compare_field("scan_done", e.scan_done, last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ACT_W-1:0] cfg_data = ACTIVE_RESET;

  annunciator_tracker tracker;
  int burst_left = 0;
  logic long_hold_req = 1'b0;

  alarm_annunciator_bank dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic send_item(input logic mode, input logic [CHAN_W-1:0] ch, input logic fault,
                           input logic [IN_CODE_W-1:0] code, input logic last,
                           input logic [1:0] cmd);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tlast <= last;
    in_tdata <= {{(IN_DATA_W - IN_ITEM_W){1'b0}}, cmd, code, fault, ch};
    do @(posedge clk); while (!in_tready);
    tracker.note_item(mode, ch, fault, code, last, cmd);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (tracker.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_active(input logic [ACT_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    tracker.active_count = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_pass(input int len);
    logic [ACT_W-1:0] act;
    logic [CHAN_W-1:0] ch;
    logic [IN_CODE_W-1:0] code;
    logic [1:0] cmd;
    logic mode;
    logic last;
    int pick;
    act = tracker.active_count;
    for (int k = 0; k < len; k++) begin
      ch = ($urandom_range(0, 9) == 0) ? CHAN_W'($urandom) : CHAN_W'($urandom_range(0, act - 1));
      code = ($urandom_range(0, 7) == 0) ? IN_CODE_W'($urandom) : IN_CODE_W'($urandom_range(0, 3));
      mode = ($urandom_range(0, 3) == 0) ? MODE_COMMAND : MODE_SCAN;
      pick = $urandom_range(0, 9);
      cmd = (pick < 5) ? CMD_ACK : (pick < 7) ? CMD_SUPPRESS :
            (pick < 9) ? CMD_UNSUPPRESS : CMD_UNKNOWN;
      last = (k == len - 1) || ($urandom_range(0, 19) == 0);
      if (k == len - 1) mode = MODE_SCAN;
      send_item(mode, ch, 1'($urandom_range(0, 1)), code, last, cmd);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_result(out_tdata, out_tlast);
  end

  initial begin : receiver
    int style;
    int style_left;
    int hold_left;
    int tick;
    style = 0;
    style_left = 0;
    hold_left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (style_left == 0) begin
        style = $urandom_range(0, 3);
        style_left = $urandom_range(20, 200);
      end
      style_left--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (style)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= (tick % 5) < 2;
          default: out_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [ACT_W-1:0] act;
    int sent;
    int len;
    tracker = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_active(ACTIVE_RESET);
    send_item(MODE_SCAN, 6'd0, 1'b1, 16'hFFFF, 1'b0, CMD_UNKNOWN);
    send_item(MODE_SCAN, 6'd0, 1'b1, 16'hFFFF, 1'b0, CMD_ACK);
    send_item(MODE_COMMAND, 6'd0, 1'b1, 16'hFFFF, 1'b1, CMD_ACK);
    send_item(MODE_SCAN, 6'd0, 1'b1, 16'h0000, 1'b0, CMD_SUPPRESS);
    send_item(MODE_SCAN, 6'd0, 1'b0, 16'h5555, 1'b1, CMD_UNSUPPRESS);
    send_item(MODE_SCAN, 6'd63, 1'b1, 16'h1234, 1'b0, CMD_SUPPRESS);
    send_item(MODE_SCAN, 6'd63, 1'b0, 16'hAAAA, 1'b0, CMD_UNKNOWN);
    send_item(MODE_COMMAND, 6'd63, 1'b0, 16'h0000, 1'b0, CMD_ACK);
    send_item(MODE_COMMAND, 6'd63, 1'b1, 16'hFFFF, 1'b0, CMD_ACK);
    send_item(MODE_SCAN, 6'd63, 1'b0, 16'h0000, 1'b1, CMD_ACK);
    send_item(MODE_COMMAND, 6'd5, 1'b0, 16'h0000, 1'b0, CMD_SUPPRESS);
    send_item(MODE_SCAN, 6'd5, 1'b1, 16'hA5A5, 1'b0, CMD_SUPPRESS);
    send_item(MODE_SCAN, 6'd5, 1'b1, 16'hA5A5, 1'b0, CMD_SUPPRESS);
    send_item(MODE_COMMAND, 6'd5, 1'b1, 16'hFFFF, 1'b0, CMD_UNSUPPRESS);
    send_item(MODE_COMMAND, 6'd5, 1'b0, 16'h0000, 1'b0, CMD_UNKNOWN);
    send_item(MODE_SCAN, 6'd5, 1'b1, 16'hA5A5, 1'b1, CMD_UNKNOWN);
    send_item(MODE_SCAN, 6'd63, 1'b1, 16'h0000, 1'b0, CMD_ACK);
    send_item(MODE_SCAN, 6'd63, 1'b0, 16'h0000, 1'b0, CMD_ACK);
    send_item(MODE_SCAN, 6'd63, 1'b1, 16'h0000, 1'b1, CMD_ACK);
    send_item(MODE_COMMAND, 6'd63, 1'b0, 16'h0000, 1'b0, CMD_ACK);
    drain_results();

    write_active(7'd1);
    send_item(MODE_SCAN, 6'd1, 1'b1, 16'hFFFF, 1'b1, CMD_SUPPRESS);
    send_item(MODE_COMMAND, 6'd63, 1'b0, 16'h0000, 1'b0, CMD_ACK);
    send_item(MODE_SCAN, 6'd0, 1'b1, 16'hFFFF, 1'b0, CMD_ACK);
    send_item(MODE_COMMAND, 6'd0, 1'b0, 16'h0000, 1'b0, CMD_SUPPRESS);
    send_item(MODE_SCAN, 6'd40, 1'b0, 16'h0000, 1'b1, CMD_ACK);
    drain_results();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: act = 7'd64;
        1: act = 7'd1;
        2: act = ACT_W'($urandom_range(3, 63));
        3: act = 7'd2;
        4: act = 7'd64;
        default: act = ACT_W'($urandom_range(3, 63));
      endcase
      write_active(act);
      if (phase == 1 || phase == 4) long_hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = $urandom_range(1, 20);
        random_pass(len);
        sent += len;
      end
      drain_results();
    end

    if (tracker.mismatches == 0 && tracker.expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

endmodule
